// ----- rtl/csi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the cardinal spline interpolator.
// No dependencies.
package csi_pkg;

	localparam int MAX_STEPS = 15;
	localparam int DIV_STEPS = 19;
	localparam int CNT_W = 4;

	localparam logic [1:0] REG_TENSION = 2'd0;
	localparam logic [1:0] REG_SEGS    = 2'd1;
	localparam logic [1:0] REG_CLOSED  = 2'd2;

	typedef enum logic [2:0] {
		SEL_W0,
		SEL_W1,
		SEL_W2,
		SEL_CUR,
		SEL_H0,
		SEL_H1,
		SEL_H2
	} sel_t;

	typedef struct packed {
		sel_t p;
		sel_t a;
		sel_t b;
		sel_t q;
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COEF,
		ST_MUL,
		ST_MUL2,
		ST_SUM,
		ST_DIV,
		ST_EMIT,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic             load_in;
		logic             coef;
		logic             mul;
		logic             mul2;
		logic             sum;
		logic             div;
		logic             emit;
		logic             run_end;
		logic             commit;
		logic             fin;
		logic [1:0]       seen;
		seg_t             seg;
		logic [CNT_W-1:0] t;
		logic [CNT_W-1:0] n;
	} csi_cmd_t;

	typedef struct packed {
		logic out_free;
	} csi_stat_t;

	function automatic seg_t make_seg(sel_t p, sel_t a, sel_t b, sel_t q);
		seg_t s;
		s.p = p;
		s.a = a;
		s.b = b;
		s.q = q;
		return s;
	endfunction

endpackage

// ----- rtl/csi_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the interpolator: segment plan per control point, step and
// divide counting, commit of the point history. Uses csi_pkg.
module csi_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic                     s_tlast,
	input  logic                     closed,
	input  logic [csi_pkg::CNT_W-1:0] n_eff,
	input  csi_pkg::csi_stat_t        stat,
	output csi_pkg::csi_cmd_t         cmd
);
	import csi_pkg::*;

	state_t           state_q, state_d;
	seg_t             segs_q [4];
	seg_t             plan [4];
	logic [2:0]       total_q, plan_total;
	logic [1:0]       seg_idx_q;
	logic [CNT_W-1:0] t_q;
	logic [4:0]       div_cnt_q;
	logic             fin_q;
	logic [1:0]       seen_q;
	logic             last_seg, last_t, accept;

	assign accept   = s_tvalid && s_tready;
	assign last_seg = ({1'b0, seg_idx_q} == total_q - 3'd1);
	assign last_t   = (t_q == n_eff);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			plan[i] = make_seg(SEL_CUR, SEL_CUR, SEL_CUR, SEL_CUR);
		end
		plan_total = 3'd0;
		if (!closed) begin
			if (seen_q >= 2'd2) begin
				plan[0] = make_seg((seen_q == 2'd3) ? SEL_W0 : SEL_W1, SEL_W1, SEL_W2, SEL_CUR);
				plan_total = 3'd1;
			end
			if (s_tlast) begin
				unique case (seen_q)
					2'd0: plan[0] = make_seg(SEL_CUR, SEL_CUR, SEL_CUR, SEL_CUR);
					2'd1: plan[0] = make_seg(SEL_W2, SEL_W2, SEL_CUR, SEL_CUR);
					default: plan[1] = make_seg(SEL_W1, SEL_W2, SEL_CUR, SEL_CUR);
				endcase
				plan_total = plan_total + 3'd1;
			end
		end else if (seen_q == 2'd3) begin
			plan[0] = make_seg(SEL_W0, SEL_W1, SEL_W2, SEL_CUR);
			plan[1] = make_seg(SEL_W1, SEL_W2, SEL_CUR, SEL_H0);
			plan[2] = make_seg(SEL_W2, SEL_CUR, SEL_H0, SEL_H1);
			plan[3] = make_seg(SEL_CUR, SEL_H0, SEL_H1, SEL_H2);
			plan_total = s_tlast ? 3'd4 : 3'd1;
		end else if (s_tlast) begin
			unique case (seen_q)
				2'd0: begin
					plan_total = 3'd1;
				end
				2'd1: begin
					plan[0] = make_seg(SEL_H0, SEL_CUR, SEL_H0, SEL_CUR);
					plan[1] = make_seg(SEL_CUR, SEL_H0, SEL_CUR, SEL_H0);
					plan_total = 3'd2;
				end
				default: begin
					plan[0] = make_seg(SEL_H0, SEL_H1, SEL_CUR, SEL_H0);
					plan[1] = make_seg(SEL_H1, SEL_CUR, SEL_H0, SEL_H1);
					plan[2] = make_seg(SEL_CUR, SEL_H0, SEL_H1, SEL_CUR);
					plan_total = 3'd3;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd         = '0;
		cmd.fin     = fin_q;
		cmd.seen    = seen_q;
		cmd.seg     = segs_q[seg_idx_q];
		cmd.t       = t_q;
		cmd.n       = n_eff;
		cmd.run_end = last_t && last_seg;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_d = (plan_total == 3'd0) ? ST_COMMIT : ST_COEF;
				end
			end
			ST_COEF: begin
				cmd.coef = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (div_cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = (last_t && last_seg) ? ST_COMMIT : ST_COEF;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			seg_idx_q <= '0;
			t_q       <= '0;
			div_cnt_q <= '0;
			fin_q     <= 1'b0;
			seen_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				segs_q[i] <= make_seg(SEL_CUR, SEL_CUR, SEL_CUR, SEL_CUR);
			end
		end else begin
			if (accept) begin
				for (int i = 0; i < 4; i++) begin
					segs_q[i] <= plan[i];
				end
				total_q   <= plan_total;
				fin_q     <= s_tlast;
				seg_idx_q <= '0;
				t_q       <= '0;
			end
			if (cmd.sum) begin
				div_cnt_q <= '0;
			end else if (cmd.div) begin
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			if (cmd.emit) begin
				if (last_t) begin
					t_q       <= '0;
					seg_idx_q <= seg_idx_q + 2'd1;
				end else begin
					t_q <= t_q + 4'd1;
				end
			end
			if (cmd.commit) begin
				if (fin_q) begin
					seen_q <= '0;
				end else if (seen_q != 2'd3) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

// ----- rtl/csi_datapath.sv -----
`timescale 1ns / 1ps
// Point history, Hermite weights, products, restoring divider and output
// register of the interpolator. Uses csi_pkg.
module csi_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csi_pkg::csi_cmd_t      cmd,
	output csi_pkg::csi_stat_t     stat,
	input  logic signed [15:0]    in_x,
	input  logic signed [15:0]    in_y,
	input  logic [14:0]           tension,
	output logic signed [17:0]    out_x,
	output logic signed [17:0]    out_y,
	output logic                  out_last,
	output logic                  out_valid,
	input  logic                  out_ready
);
	import csi_pkg::*;

	// lane 0 is x, lane 1 is y
	logic signed [15:0] win_q [2][3];
	logic signed [15:0] head_q [2][3];
	logic signed [15:0] cur_q [2];
	logic signed [15:0] op_p_q [2], op_a_q [2], op_b_q [2], op_q_q [2];
	logic signed [12:0] c1_q, c2_q, c3_q, c4_q;
	logic [11:0]        d_q;
	logic signed [28:0] m1_s2 [2], m2_s2 [2];
	logic signed [28:0] ct3_s2, ct4_s2;
	logic signed [16:0] dbp_s2 [2], dqa_s2 [2];
	logic signed [28:0] m1_s3 [2], m2_s3 [2];
	logic signed [45:0] p3_s3 [2], p4_s3 [2];
	logic [45:0]        rem_q [2];
	logic [18:0]        quo_q [2];
	logic [43:0]        dv_q;
	logic signed [17:0] res [2];
	logic signed [17:0] out_x_q, out_y_q;
	logic               out_last_q, out_valid_q;
	logic signed [15:0] tt, nn, t2, t3, n2, n3, c1, c2, c3, c4;
	logic signed [15:0] ten;

	function automatic logic signed [15:0] pick(sel_t s, logic signed [15:0] w0,
		logic signed [15:0] w1, logic signed [15:0] w2, logic signed [15:0] c,
		logic signed [15:0] h0, logic signed [15:0] h1, logic signed [15:0] h2);
		logic signed [15:0] v;
		unique case (s)
			SEL_W0:  v = w0;
			SEL_W1:  v = w1;
			SEL_W2:  v = w2;
			SEL_CUR: v = c;
			SEL_H0:  v = h0;
			SEL_H1:  v = h1;
			SEL_H2:  v = h2;
			default: v = c;
		endcase
		return v;
	endfunction

	assign ten = $signed({1'b0, tension});
	assign tt  = $signed({12'b0, cmd.t});
	assign nn  = $signed({12'b0, cmd.n});
	assign t2  = tt * tt;
	assign t3  = t2 * tt;
	assign n2  = nn * nn;
	assign n3  = n2 * nn;
	assign c1  = 16'sd2 * t3 - 16'sd3 * t2 * nn + n3;
	assign c2  = 16'sd3 * t2 * nn - 16'sd2 * t3;
	assign c3  = t3 - 16'sd2 * t2 * nn + tt * n2;
	assign c4  = t3 - t2 * nn;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_q[0] <= in_x;
			cur_q[1] <= in_y;
		end
		if (cmd.commit && !cmd.fin) begin
			for (int l = 0; l < 2; l++) begin
				if (cmd.seen != 2'd3) begin
					head_q[l][cmd.seen] <= cur_q[l];
				end
				win_q[l][0] <= win_q[l][1];
				win_q[l][1] <= win_q[l][2];
				win_q[l][2] <= cur_q[l];
			end
		end
		if (cmd.coef) begin
			c1_q <= c1[12:0];
			c2_q <= c2[12:0];
			c3_q <= c3[12:0];
			c4_q <= c4[12:0];
			d_q  <= n3[11:0];
			for (int l = 0; l < 2; l++) begin
				op_p_q[l] <= pick(cmd.seg.p, win_q[l][0], win_q[l][1], win_q[l][2],
					cur_q[l], head_q[l][0], head_q[l][1], head_q[l][2]);
				op_a_q[l] <= pick(cmd.seg.a, win_q[l][0], win_q[l][1], win_q[l][2],
					cur_q[l], head_q[l][0], head_q[l][1], head_q[l][2]);
				op_b_q[l] <= pick(cmd.seg.b, win_q[l][0], win_q[l][1], win_q[l][2],
					cur_q[l], head_q[l][0], head_q[l][1], head_q[l][2]);
				op_q_q[l] <= pick(cmd.seg.q, win_q[l][0], win_q[l][1], win_q[l][2],
					cur_q[l], head_q[l][0], head_q[l][1], head_q[l][2]);
			end
		end
		if (cmd.mul) begin
			ct3_s2 <= c3_q * ten;
			ct4_s2 <= c4_q * ten;
			for (int l = 0; l < 2; l++) begin
				m1_s2[l]  <= c1_q * op_a_q[l];
				m2_s2[l]  <= c2_q * op_b_q[l];
				dbp_s2[l] <= op_b_q[l] - op_p_q[l];
				dqa_s2[l] <= op_q_q[l] - op_a_q[l];
			end
		end
		if (cmd.mul2) begin
			for (int l = 0; l < 2; l++) begin
				m1_s3[l] <= m1_s2[l];
				m2_s3[l] <= m2_s2[l];
				p3_s3[l] <= ct3_s2 * dbp_s2[l];
				p4_s3[l] <= ct4_s2 * dqa_s2[l];
			end
		end
		if (cmd.sum) begin
			// bias by den<<32 keeps the dividend non-negative
			dv_q <= {d_q, 32'b0};
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= 46'(((48'(m1_s3[l]) + 48'(m2_s3[l])) <<< 14)
					+ 48'(p3_s3[l]) + 48'(p4_s3[l])
					+ {23'b0, d_q, 13'b0} + {4'b0, d_q, 32'b0});
				quo_q[l] <= '0;
			end
		end
		if (cmd.div) begin
			dv_q <= dv_q >> 1;
			for (int l = 0; l < 2; l++) begin
				if (rem_q[l] >= {2'b0, dv_q}) begin
					rem_q[l] <= rem_q[l] - {2'b0, dv_q};
					quo_q[l] <= {quo_q[l][17:0], 1'b1};
				end else begin
					quo_q[l] <= {quo_q[l][17:0], 1'b0};
				end
			end
		end
		if (cmd.emit) begin
			out_x_q    <= res[0];
			out_y_q    <= res[1];
			out_last_q <= cmd.run_end;
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic signed [19:0] qs;
			qs = $signed({1'b0, quo_q[l]}) - 20'sd262144;
			if (qs > 20'sd131071) begin
				res[l] = 18'sd131071;
			end else if (qs < -20'sd131072) begin
				res[l] = -18'sd131072;
			end else begin
				res[l] = qs[17:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_x         = out_x_q;
	assign out_y         = out_y_q;
	assign out_last      = out_last_q;
	assign out_valid     = out_valid_q;

endmodule

// ----- rtl/cardinal_spline_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Cardinal spline interpolator: config registers, sequencer and datapath.
// Each curve point passes through weights, two multiply stages, sum, a
// 19-step restoring divider and output load (held while the output register
// is occupied); a control point yields 0 to 64 results, plus accept and commit.
// One point is handled at a time; the output register frees the sink side.
// Reset (arst_n, asynchronous) clears history and restores the registers.
module cardinal_spline_interpolator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // point_x [15:0], point_y [31:16]
	input  logic        s_tlast,  // final_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // curve_x [17:0], curve_y [35:18], zero pad
	output logic        m_tlast,  // run_end
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	import csi_pkg::*;

	logic [14:0]        tension_q;
	logic [3:0]         seg_cnt_q;
	logic               closed_q;
	logic [3:0]         n_eff;
	csi_cmd_t           cmd;
	csi_stat_t          stat;
	logic signed [17:0] out_x, out_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= 15'd8192;
			seg_cnt_q <= 4'd8;
			closed_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TENSION: tension_q <= cfg_data;
				REG_SEGS:    seg_cnt_q <= cfg_data[3:0];
				REG_CLOSED:  closed_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (seg_cnt_q == 4'd0) begin
			n_eff = 4'd1;
		end else if (seg_cnt_q > 4'(MAX_STEPS)) begin
			n_eff = 4'(MAX_STEPS);
		end else begin
			n_eff = seg_cnt_q;
		end
	end

	csi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.closed   (closed_q),
		.n_eff    (n_eff),
		.stat     (stat),
		.cmd      (cmd)
	);

	csi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_x      ($signed(s_tdata[15:0])),
		.in_y      ($signed(s_tdata[31:16])),
		.tension   (tension_q),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_last  (m_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready)
	);

	assign m_tdata = {4'b0, out_y, out_x};

endmodule

// ----- rtl/csi_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the interpolator, bound to the top level.
// Depends on cardinal_spline_interpolator_unit.
module csi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transfer taken while busy");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result appeared right after input transfer");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:36] == 4'b0)
		else $error("padding bits set");

endmodule

bind cardinal_spline_interpolator_unit csi_checker u_csi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- verif/cardinal_spline_interpolator_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for cardinal_spline_interpolator_unit: a built-in spline predictor checks
// every output point in order under random stalls. Depends on the RTL top level and csi_pkg.
module cardinal_spline_interpolator_unit_tb;

	import csi_pkg::*;

	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam int STEPS_MAX = 15;
	localparam int SETTLE = 80;
	localparam int HOLD_LEN = 3000;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               fin;
	} ctrl_pt_t;

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic               last;
	} curve_pt_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;

	ctrl_pt_t  pending_pts[$];
	curve_pt_t curve_q[$];
	int        errors = 0;
	int        src_idle = 0;
	int        sink_idle = 0;
	int        sink_hold = 0;
	int        acc_cnt = 0;
	int        acc_done = 0;
	int        hold_reqs = 0;
	int        hold_acks = 0;

	// predictor copy of registers and history
	longint ten_r = 8192;
	longint segs_r = 8;
	bit     ring_r = 0;
	longint hx[3], hy[3], wx[3], wy[3];
	int     seen_r = 0;

	cardinal_spline_interpolator_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic longint floor_div(input longint num, input longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic logic signed [17:0] hermite_coord(input longint t, input longint n,
			input longint p, input longint a, input longint b, input longint q);
		longint d, t2, t3, c1, c2, c3, c4, num, v;
		d = n * n * n;
		t2 = t * t;
		t3 = t2 * t;
		c1 = 2 * t3 - 3 * t2 * n + d;
		c2 = -2 * t3 + 3 * t2 * n;
		c3 = t3 - 2 * t2 * n + t * n * n;
		c4 = t3 - t2 * n;
		num = (c1 * a + c2 * b) * 16384 + c3 * ten_r * (b - p) + c4 * ten_r * (q - a);
		v = floor_div(num + d * 8192, d * 16384);
		if (v > 131071)
			v = 131071;
		if (v < -131072)
			v = -131072;
		return v[17:0];
	endfunction

	task automatic add_segment(input longint px, input longint py, input longint ax,
			input longint ay, input longint bx, input longint by, input longint qx,
			input longint qy);
		longint n;
		curve_pt_t pt;
		n = segs_r;
		if (n < 1)
			n = 1;
		if (n > STEPS_MAX)
			n = STEPS_MAX;
		for (longint t = 0; t <= n; t++) begin
			pt.x = hermite_coord(t, n, px, ax, bx, qx);
			pt.y = hermite_coord(t, n, py, ay, by, qy);
			pt.last = 1'b0;
			curve_q.push_back(pt);
		end
	endtask

	task automatic predict_point(input ctrl_pt_t c);
		int base_cnt, seen, n, j;
		longint cx, cy;
		longint rx[4], ry[4];
		base_cnt = curve_q.size();
		seen = seen_r;
		cx = c.x;
		cy = c.y;
		if (!ring_r) begin
			if (seen >= 2) begin
				if (seen >= 3)
					add_segment(wx[0], wy[0], wx[1], wy[1], wx[2], wy[2], cx, cy);
				else
					add_segment(wx[1], wy[1], wx[1], wy[1], wx[2], wy[2], cx, cy);
			end
			if (c.fin) begin
				if (seen == 0)
					add_segment(cx, cy, cx, cy, cx, cy, cx, cy);
				else if (seen == 1)
					add_segment(wx[2], wy[2], wx[2], wy[2], cx, cy, cx, cy);
				else
					add_segment(wx[1], wy[1], wx[2], wy[2], cx, cy, cx, cy);
			end
		end else if (seen >= 3) begin
			add_segment(wx[0], wy[0], wx[1], wy[1], wx[2], wy[2], cx, cy);
			if (c.fin) begin
				add_segment(wx[1], wy[1], wx[2], wy[2], cx, cy, hx[0], hy[0]);
				add_segment(wx[2], wy[2], cx, cy, hx[0], hy[0], hx[1], hy[1]);
				add_segment(cx, cy, hx[0], hy[0], hx[1], hy[1], hx[2], hy[2]);
			end
		end else if (c.fin) begin
			n = seen + 1;
			for (int i = 0; i < seen; i++) begin
				rx[i] = hx[i];
				ry[i] = hy[i];
			end
			rx[seen] = cx;
			ry[seen] = cy;
			for (int i = 1; i <= n; i++) begin
				j = (i == n) ? 0 : i;
				add_segment(rx[(j + n - 1) % n], ry[(j + n - 1) % n], rx[j], ry[j],
					rx[(j + 1) % n], ry[(j + 1) % n], rx[(j + 2) % n], ry[(j + 2) % n]);
			end
		end
		if (c.fin) begin
			seen_r = 0;
		end else begin
			if (seen < 3) begin
				hx[seen] = cx;
				hy[seen] = cy;
			end
			wx[0] = wx[1];
			wy[0] = wy[1];
			wx[1] = wx[2];
			wy[1] = wy[2];
			wx[2] = cx;
			wy[2] = cy;
			seen_r = (seen < 3) ? seen + 1 : 3;
		end
		if (curve_q.size() > base_cnt)
			curve_q[curve_q.size() - 1].last = 1'b1;
	endtask

	// driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_point(pending_pts[0]);
			void'(pending_pts.pop_front());
			acc_cnt++;
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || acc_done != acc_cnt) begin
			acc_done <= acc_cnt;
			if (arst_n && pending_pts.size() > 0 && $urandom_range(99) >= src_idle) begin
				s_tdata <= {pending_pts[0].y, pending_pts[0].x};
				s_tlast <= pending_pts[0].fin;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side stalls
	always @(negedge clk) begin
		if (hold_reqs != hold_acks) begin
			hold_acks <= hold_reqs;
			sink_hold <= HOLD_LEN;
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (curve_q.size() == 0) begin
				report("output transfer with nothing expected");
			end else begin
				if ($signed(m_tdata[17:0]) !== curve_q[0].x)
					report($sformatf("curve_x got %0d exp %0d", $signed(m_tdata[17:0]),
						curve_q[0].x));
				if ($signed(m_tdata[35:18]) !== curve_q[0].y)
					report($sformatf("curve_y got %0d exp %0d", $signed(m_tdata[35:18]),
						curve_q[0].y));
				if (m_tlast !== curve_q[0].last)
					report($sformatf("run_end got %0b exp %0b", m_tlast, curve_q[0].last));
				void'(curve_q.pop_front());
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TENSION: ten_r = val;
			REG_SEGS:    segs_r = val[3:0];
			REG_CLOSED:  ring_r = val[0];
			default: ;
		endcase
	endtask

	task automatic queue_pt(input logic [15:0] x, input logic [15:0] y, input logic fin);
		ctrl_pt_t c;
		c.x = x;
		c.y = y;
		c.fin = fin;
		pending_pts.push_back(c);
	endtask

	task automatic drain();
		wait (pending_pts.size() == 0 && !s_tvalid && curve_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(200)) - 16'd100;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_curve(input int len);
		for (int i = 0; i < len; i++)
			queue_pt(rand_coord(), rand_coord(), i == len - 1);
	endtask

	initial begin
		logic [14:0] tv;
		logic [14:0] sv;
		int budget;
		int len;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TENSION;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, open curves
		src_idle = 30;
		sink_idle = 49;
		queue_pt(16'h7FFF, 16'h8000, 1'b1);
		queue_pt(16'h8000, 16'h7FFF, 1'b0);
		queue_pt(16'h7FFF, 16'h8000, 1'b1);
		queue_pt(16'd10, -16'd20, 1'b0);
		queue_pt(16'h7FFF, 16'h7FFF, 1'b0);
		queue_pt(16'h8000, 16'h8000, 1'b0);
		queue_pt(16'h7FFF, 16'h0000, 1'b0);
		queue_pt(16'hFFFF, 16'h5555, 1'b1);
		drain();
		write_reg(REG_SPARE, 15'h7FFF);
		write_reg(REG_TENSION, 15'h7FFF);
		write_reg(REG_SEGS, 15'd0);
		write_reg(REG_CLOSED, 15'd1);
		queue_pt(16'h1234, -16'd5, 1'b1);
		queue_pt(16'h7FFF, 16'h8000, 1'b0);
		queue_pt(16'h8000, 16'h7FFF, 1'b1);
		queue_pt(16'd100, 16'd0, 1'b0);
		queue_pt(16'd0, 16'd100, 1'b0);
		queue_pt(-16'd100, 16'd0, 1'b1);
		queue_pt(16'h7FFF, 16'h7FFF, 1'b0);
		queue_pt(16'h8000, 16'h8000, 1'b0);
		queue_pt(16'h7FFF, 16'h8000, 1'b0);
		queue_pt(16'h8000, 16'h7FFF, 1'b0);
		queue_pt(16'hAAAA, 16'h5555, 1'b1);
		drain();

		// random phases
		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 3) begin
				src_idle = 30;
				sink_idle = 49;
			end else if (ph < 6) begin
				src_idle = 49;
				sink_idle = 30;
			end else begin
				src_idle = 0;
				sink_idle = 0;
			end
			case (ph % 4)
				0: tv = 15'd0;
				1: tv = 15'h7FFF;
				default: tv = 15'($urandom_range(32767));
			endcase
			case (ph)
				0: sv = 15'd1;
				3: sv = 15'd15;
				5: sv = 15'd0;
				default: sv = 15'($urandom_range(6, 1));
			endcase
			write_reg(REG_TENSION, tv);
			write_reg(REG_SEGS, sv);
			write_reg(REG_CLOSED, 15'(ph % 2));
			budget = 42;
			while (budget > 0) begin
				len = ($urandom_range(9) == 0) ? 1 : $urandom_range(8, 2);
				if (len > budget)
					len = budget;
				queue_curve(len);
				budget -= len;
			end
			if (ph == 1) begin
				wait (pending_pts.size() < 38);
				hold_reqs++;
			end
			drain();
		end

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
